FILE: design/shp_pkg.sv
// Shared types and constants of the SOME/IP header parser.
package shp_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
    localparam int COUNT_W = 33;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] LENGTH_BASE = 33'd8;

    localparam int OFS_SERVICE = 0;
    localparam int OFS_METHOD = 2;
    localparam int OFS_LENGTH = 4;
    localparam int OFS_CLIENT = 8;
    localparam int OFS_SESSION = 10;
    localparam int OFS_PROTO_VER = 12;
    localparam int OFS_IFACE_VER = 13;
    localparam int OFS_MSG_TYPE = 14;
    localparam int OFS_RET_CODE = 15;

    localparam logic [7:0] MT_REQUEST = 8'h00;
    localparam logic [7:0] MT_REQUEST_NO_RETURN = 8'h01;
    localparam logic [7:0] MT_NOTIFICATION = 8'h02;
    localparam logic [7:0] MT_RESPONSE = 8'h80;
    localparam logic [7:0] MT_ERROR = 8'h81;

    localparam logic [7:0] RC_OK = 8'h00;
    localparam logic [7:0] RC_UNKNOWN_METHOD = 8'h03;
    localparam logic [7:0] RC_MALFORMED_MESSAGE = 8'h09;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_BAD_LENGTH,
        ST_MISMATCH,
        ST_VERSION,
        ST_TYPE,
        ST_RETURN_CODE
    } status_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data;
        logic        last;
        status_t     status;
        logic [15:0] srv_id;
        logic [15:0] mthd_id;
        logic [15:0] clnt_id;
        logic [15:0] sess_id;
        logic [7:0]  iface_ver;
        logic [7:0]  msg_type;
        logic [7:0]  ret_code;
    } result_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_ctrl_t;

endpackage

FILE: design/shp_front.sv
// Front end: byte counter, header capture, frame checks and result formation.
module shp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 frame_end,
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_data,
    input  logic                 q_full,
    output shp_pkg::queue_ctrl_t q_ctrl,
    output shp_pkg::result_t     push_data
);

    logic [shp_pkg::COUNT_W-1:0] count_reg;
    logic [shp_pkg::COUNT_W-1:0] count_next;
    logic [shp_pkg::COUNT_W-1:0] count_inc;
    logic [shp_pkg::COUNT_W-1:0] len_total;
    logic [7:0]                  expected_version_reg;
    logic [7:0]                  hdr_reg [shp_pkg::HEADER_BYTES];
    logic [7:0]                  hdr_now [shp_pkg::HEADER_BYTES];
    logic [31:0]                 len;
    logic                        accept;
    logic                        payload;
    logic                        saturated;
    logic                        type_known;
    logic                        code_known;
    shp_pkg::status_t            status;
    logic [shp_pkg::HDR_IDX_W-1:0] wr_idx;

    assign accept   = in_valid & ~q_full;
    assign in_stall = q_full;
    assign payload  = count_reg >= shp_pkg::COUNT_W'(shp_pkg::HEADER_BYTES);
    assign wr_idx   = count_reg[shp_pkg::HDR_IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < shp_pkg::HEADER_BYTES; i++)
        begin
            if (!payload && wr_idx == shp_pkg::HDR_IDX_W'(i))
            begin
                hdr_now[i] = data_byte;
            end
            else
            begin
                hdr_now[i] = hdr_reg[i];
            end
        end
    end

    assign count_inc = (count_reg == shp_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign saturated = count_inc == shp_pkg::COUNT_MAX;
    assign count_next = frame_end ? '0 : count_inc;

    assign len = {hdr_now[shp_pkg::OFS_LENGTH], hdr_now[shp_pkg::OFS_LENGTH + 1],
                  hdr_now[shp_pkg::OFS_LENGTH + 2], hdr_now[shp_pkg::OFS_LENGTH + 3]};
    assign len_total = {1'b0, len} + shp_pkg::LENGTH_BASE;

    assign type_known = hdr_now[shp_pkg::OFS_MSG_TYPE] inside {
        shp_pkg::MT_REQUEST, shp_pkg::MT_REQUEST_NO_RETURN, shp_pkg::MT_NOTIFICATION,
        shp_pkg::MT_RESPONSE, shp_pkg::MT_ERROR};
    assign code_known = hdr_now[shp_pkg::OFS_RET_CODE] inside {
        [shp_pkg::RC_OK:shp_pkg::RC_UNKNOWN_METHOD], shp_pkg::RC_MALFORMED_MESSAGE};

    always_comb
    begin
        if (count_inc < shp_pkg::COUNT_W'(shp_pkg::HEADER_BYTES))
        begin
            status = shp_pkg::ST_SHORT;
        end
        else if ({1'b0, len} < shp_pkg::LENGTH_BASE)
        begin
            status = shp_pkg::ST_BAD_LENGTH;
        end
        else if (saturated || count_inc != len_total)
        begin
            status = shp_pkg::ST_MISMATCH;
        end
        else if (hdr_now[shp_pkg::OFS_PROTO_VER] != expected_version_reg)
        begin
            status = shp_pkg::ST_VERSION;
        end
        else if (!type_known)
        begin
            status = shp_pkg::ST_TYPE;
        end
        else if (!code_known)
        begin
            status = shp_pkg::ST_RETURN_CODE;
        end
        else
        begin
            status = shp_pkg::ST_OK;
        end
    end

    always_comb
    begin
        push_data          = '0;
        push_data.has_byte = payload;
        push_data.data     = payload ? data_byte : 8'd0;
        push_data.last     = frame_end;
        push_data.status   = frame_end ? status : shp_pkg::ST_OK;
        if (frame_end && status == shp_pkg::ST_OK)
        begin
            push_data.srv_id  = {hdr_now[shp_pkg::OFS_SERVICE],
                                 hdr_now[shp_pkg::OFS_SERVICE + 1]};
            push_data.mthd_id = {hdr_now[shp_pkg::OFS_METHOD],
                                 hdr_now[shp_pkg::OFS_METHOD + 1]};
            push_data.clnt_id = {hdr_now[shp_pkg::OFS_CLIENT],
                                 hdr_now[shp_pkg::OFS_CLIENT + 1]};
            push_data.sess_id = {hdr_now[shp_pkg::OFS_SESSION],
                                 hdr_now[shp_pkg::OFS_SESSION + 1]};
            push_data.iface_ver = hdr_now[shp_pkg::OFS_IFACE_VER];
            push_data.msg_type  = hdr_now[shp_pkg::OFS_MSG_TYPE];
            push_data.ret_code  = hdr_now[shp_pkg::OFS_RET_CODE];
        end
    end

    assign q_ctrl.push = accept & (payload | frame_end);
    assign q_ctrl.full = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg            <= '0;
            expected_version_reg <= 8'd1;
            for (int i = 0; i < shp_pkg::HEADER_BYTES; i++)
            begin
                hdr_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                expected_version_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
                if (!payload)
                begin
                    hdr_reg[wr_idx] <= data_byte;
                end
            end
        end
    end

endmodule

FILE: design/shp_queue.sv
// Short result queue between the front end and the output stage.
module shp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shp_pkg::queue_ctrl_t q_ctrl,
    input  shp_pkg::result_t     push_data,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output shp_pkg::result_t     pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    shp_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = q_ctrl.push & ~q_ctrl.full;
    assign do_pop   = pop & ~empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!do_push && do_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/shp_back.sv
// Output stage: registered result word with valid and stall handshake.
module shp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  shp_pkg::result_t pop_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output shp_pkg::result_t out_word
);

    logic             out_valid_reg;
    logic             out_valid_next;
    shp_pkg::result_t out_word_reg;

    assign pop            = ~empty & (~out_valid_reg | ~out_stall);
    assign out_valid_next = pop | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg <= pop_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: design/someip_header_parser.sv
// Top level of the SOME/IP header parser.
// The parser takes one frame byte per cycle with no gaps of its own: a new byte
// is accepted in every cycle in which in_valid is high and in_stall is low. The
// first 16 bytes of a frame are captured as the header; later bytes come out as
// payload words at once. The final byte (frame_end) yields a word with last set,
// the check status and, for status ok, the decoded header fields. A result word
// is written into the queue at the edge that accepts its byte, then moves into
// the output register. A queue of QUEUE_DEPTH words lies between the checking
// front end and the output register, so in_stall rises only once the output
// register and every queue entry hold words the output side has yet to take.
module someip_header_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        has_byte,
    output logic [7:0]  data,
    output logic        last,
    output logic [2:0]  status,
    output logic [15:0] srv_id,
    output logic [15:0] mthd_id,
    output logic [15:0] clnt_id,
    output logic [15:0] sess_id,
    output logic [7:0]  iface_ver,
    output logic [7:0]  msg_type,
    output logic [7:0]  ret_code
);

    shp_pkg::queue_ctrl_t q_ctrl;
    shp_pkg::result_t     push_data;
    shp_pkg::result_t     pop_data;
    shp_pkg::result_t     out_word;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;

    shp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_ctrl    (q_ctrl),
        .push_data (push_data)
    );

    shp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_ctrl    (q_ctrl),
        .push_data (push_data),
        .full      (q_full),
        .empty     (q_empty),
        .pop       (q_pop),
        .pop_data  (pop_data)
    );

    shp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .pop_data  (pop_data),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign has_byte  = out_word.has_byte;
    assign data      = out_word.data;
    assign last      = out_word.last;
    assign status    = out_word.status;
    assign srv_id    = out_word.srv_id;
    assign mthd_id   = out_word.mthd_id;
    assign clnt_id   = out_word.clnt_id;
    assign sess_id   = out_word.sess_id;
    assign iface_ver = out_word.iface_ver;
    assign msg_type  = out_word.msg_type;
    assign ret_code  = out_word.ret_code;

endmodule

FILE: design/shp_checker.sv
// Port-level checker for the SOME/IP header parser and its bind.
module shp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        has_byte,
    input logic [7:0]  data,
    input logic        last,
    input logic [2:0]  status,
    input logic [15:0] srv_id,
    input logic [15:0] mthd_id,
    input logic [15:0] clnt_id,
    input logic [15:0] sess_id,
    input logic [7:0]  iface_ver,
    input logic [7:0]  msg_type,
    input logic [7:0]  ret_code
);

    a_nonfinal_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> has_byte && status == shp_pkg::ST_OK)
        else $error("non-final word without payload byte or with status");

    a_header_byte_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> data == 8'd0)
        else $error("data set on a word without payload byte");

    a_failed_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != shp_pkg::ST_OK |->
            srv_id == 16'd0 && mthd_id == 16'd0 && clnt_id == 16'd0 &&
            sess_id == 16'd0 && iface_ver == 8'd0 &&
            msg_type == 8'd0 && ret_code == 8'd0)
        else $error("header fields set on a failed frame");

    a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data) && $stable(last) &&
            $stable(status))
        else $error("stalled output word changed");

endmodule

bind someip_header_parser shp_checker u_shp_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the SOME/IP header parser, with driver, monitor and predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 400000;
    localparam int PHASE_BYTES = 128;
    localparam logic [7:0] KNOWN_TYPES [5] = '{shp_pkg::MT_REQUEST,
        shp_pkg::MT_REQUEST_NO_RETURN, shp_pkg::MT_NOTIFICATION, shp_pkg::MT_RESPONSE,
        shp_pkg::MT_ERROR};

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        has_byte;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  status;
    logic [15:0] srv_id;
    logic [15:0] mthd_id;
    logic [15:0] clnt_id;
    logic [15:0] sess_id;
    logic [7:0]  iface_ver;
    logic [7:0]  msg_type;
    logic [7:0]  ret_code;

    frame_byte_t      byte_queue [$];
    shp_pkg::result_t expected_words [$];

    logic [shp_pkg::COUNT_W-1:0] frame_bytes = '0;
    logic [7:0]  hdr_seen [shp_pkg::HEADER_BYTES] = '{default: 8'h00};
    logic [7:0]  proto_version = 8'h01;

    logic [7:0]  hdr_build [shp_pkg::HEADER_BYTES];
    logic [7:0]  cur_version = 8'h01;
    int          pushed_bytes = 0;

    bit          in_taken = 1'b0;
    int          inputs_taken = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          next_hold_at = 150;
    int          stall_pct = 0;
    int          seg_left = 0;
    int          mismatches = 0;
    int          cycles = 0;

    someip_header_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .has_byte  (has_byte),
        .data      (data),
        .last      (last),
        .status    (status),
        .srv_id    (srv_id),
        .mthd_id   (mthd_id),
        .clnt_id   (clnt_id),
        .sess_id   (sess_id),
        .iface_ver (iface_ver),
        .msg_type  (msg_type),
        .ret_code  (ret_code)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Returns 1 when the byte yields an output word, and updates the frame state.
    function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                       output shp_pkg::result_t r);
        logic             is_payload;
        logic [31:0]      len;
        shp_pkg::status_t st;
        is_payload = (frame_bytes >= shp_pkg::HEADER_BYTES);
        r = '0;
        if (!is_payload)
            hdr_seen[frame_bytes[shp_pkg::HDR_IDX_W-1:0]] = b;
        if (frame_bytes != shp_pkg::COUNT_MAX)
            frame_bytes = frame_bytes + 1'b1;
        if (!is_payload && !fin)
            return 1'b0;
        r.has_byte = is_payload;
        r.data = is_payload ? b : 8'h00;
        if (!fin)
            return 1'b1;
        r.last = 1'b1;
        if (frame_bytes < shp_pkg::HEADER_BYTES)
            st = shp_pkg::ST_SHORT;
        else
        begin
            len = {hdr_seen[shp_pkg::OFS_LENGTH], hdr_seen[shp_pkg::OFS_LENGTH+1],
                   hdr_seen[shp_pkg::OFS_LENGTH+2], hdr_seen[shp_pkg::OFS_LENGTH+3]};
            if ({1'b0, len} < shp_pkg::LENGTH_BASE)
                st = shp_pkg::ST_BAD_LENGTH;
            else if (frame_bytes == shp_pkg::COUNT_MAX ||
                     frame_bytes != {1'b0, len} + shp_pkg::LENGTH_BASE)
                st = shp_pkg::ST_MISMATCH;
            else if (hdr_seen[shp_pkg::OFS_PROTO_VER] != proto_version)
                st = shp_pkg::ST_VERSION;
            else if (!(hdr_seen[shp_pkg::OFS_MSG_TYPE] inside {shp_pkg::MT_REQUEST,
                     shp_pkg::MT_REQUEST_NO_RETURN, shp_pkg::MT_NOTIFICATION,
                     shp_pkg::MT_RESPONSE, shp_pkg::MT_ERROR}))
                st = shp_pkg::ST_TYPE;
            else if (hdr_seen[shp_pkg::OFS_RET_CODE] > shp_pkg::RC_UNKNOWN_METHOD &&
                     hdr_seen[shp_pkg::OFS_RET_CODE] != shp_pkg::RC_MALFORMED_MESSAGE)
                st = shp_pkg::ST_RETURN_CODE;
            else
                st = shp_pkg::ST_OK;
        end
        r.status = st;
        if (st == shp_pkg::ST_OK)
        begin
            r.srv_id = {hdr_seen[shp_pkg::OFS_SERVICE], hdr_seen[shp_pkg::OFS_SERVICE+1]};
            r.mthd_id = {hdr_seen[shp_pkg::OFS_METHOD], hdr_seen[shp_pkg::OFS_METHOD+1]};
            r.clnt_id = {hdr_seen[shp_pkg::OFS_CLIENT], hdr_seen[shp_pkg::OFS_CLIENT+1]};
            r.sess_id = {hdr_seen[shp_pkg::OFS_SESSION], hdr_seen[shp_pkg::OFS_SESSION+1]};
            r.iface_ver = hdr_seen[shp_pkg::OFS_IFACE_VER];
            r.msg_type = hdr_seen[shp_pkg::OFS_MSG_TYPE];
            r.ret_code = hdr_seen[shp_pkg::OFS_RET_CODE];
        end
        frame_bytes = '0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        shp_pkg::result_t r;
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n && cfg_write)
            proto_version = cfg_data;
        if (in_taken)
        begin
            inputs_taken++;
            if (decode_byte(data_byte, frame_end, r))
                expected_words = {expected_words, r};
        end
    end

    always @(negedge clk)
    begin
        frame_byte_t word;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                word = byte_queue.pop_front();
                in_valid <= 1'b1;
                data_byte <= word.value;
                frame_end <= word.fin;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // The receiver draws a new stall rate at the end of each random-length segment and now and then
    // holds off long enough for the parser to fill up and stall its input.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (inputs_taken >= next_hold_at)
        begin
            out_stall <= 1'b1;
            hold_left = 120;
            next_hold_at += 350;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (seg_left > 0)
                seg_left--;
            else
            begin
                seg_left = $urandom_range(50, 200);
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        shp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: word with no expectation, expected none, got data %0h last %0b",
                         $realtime, data, last);
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("has_byte", want.has_byte, has_byte);
                check_field("data", want.data, data);
                check_field("last", want.last, last);
                check_field("status", want.status, status);
                check_field("srv_id", want.srv_id, srv_id);
                check_field("mthd_id", want.mthd_id, mthd_id);
                check_field("clnt_id", want.clnt_id, clnt_id);
                check_field("sess_id", want.sess_id, sess_id);
                check_field("iface_ver", want.iface_ver, iface_ver);
                check_field("msg_type", want.msg_type, msg_type);
                check_field("ret_code", want.ret_code, ret_code);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic set_length(input logic [31:0] len);
        {hdr_build[shp_pkg::OFS_LENGTH], hdr_build[shp_pkg::OFS_LENGTH+1],
         hdr_build[shp_pkg::OFS_LENGTH+2], hdr_build[shp_pkg::OFS_LENGTH+3]} = len;
    endtask

    task automatic fill_header(input int payload);
        foreach (hdr_build[i])
            hdr_build[i] = 8'($urandom);
        set_length(32'(payload + 8));
        hdr_build[shp_pkg::OFS_PROTO_VER] = cur_version;
        hdr_build[shp_pkg::OFS_MSG_TYPE] = KNOWN_TYPES[$urandom_range(4)];
        hdr_build[shp_pkg::OFS_RET_CODE] = ($urandom_range(4) == 0)
            ? shp_pkg::RC_MALFORMED_MESSAGE
            : 8'($urandom_range(shp_pkg::RC_UNKNOWN_METHOD));
    endtask

    task automatic push_frame(input int total);
        frame_byte_t word;
        for (int i = 0; i < total; i++)
        begin
            word.value = (i < shp_pkg::HEADER_BYTES) ? hdr_build[i] : 8'($urandom);
            word.fin = (i == total - 1);
            byte_queue = {byte_queue, word};
        end
        pushed_bytes += total;
    endtask

    task automatic random_frame();
        int payload;
        int total;
        payload = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
        fill_header(payload);
        total = shp_pkg::HEADER_BYTES + payload;
        case ($urandom_range(15))
            0: total = $urandom_range(1, shp_pkg::HEADER_BYTES - 1);
            1: set_length($urandom_range(7));
            2: set_length($urandom);
            3: total += $urandom_range(1, 3);
            4: hdr_build[shp_pkg::OFS_PROTO_VER] = cur_version ^ 8'($urandom_range(1, 255));
            5: hdr_build[shp_pkg::OFS_MSG_TYPE] = 8'($urandom);
            6: hdr_build[shp_pkg::OFS_RET_CODE] = 8'($urandom);
            default: ;
        endcase
        push_frame(total);
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_version(input logic [7:0] v);
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_version = v;
    endtask

    initial
    begin
        logic [7:0] versions [5];
        versions = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'h01};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fill_header(0);
        hdr_build[0] = 8'hFF;
        push_frame(1);
        fill_header(0);
        push_frame(shp_pkg::HEADER_BYTES - 1);
        fill_header(0);
        hdr_build[shp_pkg::OFS_SERVICE] = 8'hFF;
        hdr_build[shp_pkg::OFS_SERVICE+1] = 8'hFF;
        hdr_build[shp_pkg::OFS_METHOD] = 8'h00;
        hdr_build[shp_pkg::OFS_METHOD+1] = 8'h00;
        hdr_build[shp_pkg::OFS_CLIENT] = 8'hFF;
        hdr_build[shp_pkg::OFS_CLIENT+1] = 8'hFF;
        hdr_build[shp_pkg::OFS_SESSION] = 8'h00;
        hdr_build[shp_pkg::OFS_SESSION+1] = 8'h00;
        hdr_build[shp_pkg::OFS_IFACE_VER] = 8'hFF;
        hdr_build[shp_pkg::OFS_MSG_TYPE] = shp_pkg::MT_REQUEST;
        hdr_build[shp_pkg::OFS_RET_CODE] = shp_pkg::RC_OK;
        push_frame(shp_pkg::HEADER_BYTES);
        fill_header(2);
        hdr_build[shp_pkg::OFS_MSG_TYPE] = shp_pkg::MT_ERROR;
        hdr_build[shp_pkg::OFS_RET_CODE] = shp_pkg::RC_MALFORMED_MESSAGE;
        push_frame(shp_pkg::HEADER_BYTES + 2);
        fill_header(0);
        set_length(32'd7);
        push_frame(shp_pkg::HEADER_BYTES);
        fill_header(0);
        set_length(32'hFFFF_FFFF);
        push_frame(shp_pkg::HEADER_BYTES + 1);
        fill_header(0);
        hdr_build[shp_pkg::OFS_PROTO_VER] = 8'h02;
        push_frame(shp_pkg::HEADER_BYTES);
        fill_header(1);
        hdr_build[shp_pkg::OFS_MSG_TYPE] = 8'h03;
        hdr_build[shp_pkg::OFS_RET_CODE] = 8'h04;
        push_frame(shp_pkg::HEADER_BYTES + 1);
        fill_header(0);
        hdr_build[shp_pkg::OFS_RET_CODE] = 8'h04;
        push_frame(shp_pkg::HEADER_BYTES);

        foreach (versions[p])
        begin
            set_version(versions[p]);
            pushed_bytes = 0;
            while (pushed_bytes < PHASE_BYTES)
                random_frame();
        end

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
design/shp_pkg.sv
design/shp_front.sv
design/shp_queue.sv
design/shp_back.sv
design/someip_header_parser.sv
design/shp_checker.sv
tb/testbench.sv
